/* design/c2s_pkg.sv */
package c2s_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STAGES_DEF   = 18;

    // datapath: coordinates scaled so that full scale sits near 2^57
    localparam int DP_W      = 64;
    localparam int ANG_W     = 32;
    localparam int ACC_FRAC  = 22;
    localparam int GUARD_TOP = 58;

    // cordic gain 1.6467602581 in q30
    localparam logic [DP_W-1:0] GAIN_Q30 = 64'd1768195363;

    localparam logic signed [ANG_W-1:0] DEG_90  = 32'sd377487360;
    localparam logic signed [ANG_W-1:0] DEG_180 = 32'sd754974720;
    localparam logic signed [ANG_W-1:0] DEG_270 = 32'sd1132462080;
    localparam logic signed [ANG_W-1:0] DEG_360 = 32'sd1509949440;

    // atan(2^-i) in degrees, q22
    localparam logic signed [ANG_W-1:0] ATAN_DEG [32] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29,
        32'sd14,        32'sd7,         32'sd4,        32'sd2,
        32'sd1,         32'sd0,         32'sd0,        32'sd0
    };

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic z_zero;
        logic x_neg;
        logic y_pos;
        logic z_pos;
    } t_flags;

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [DP_W-1:0]  zg;
        logic signed [DP_W-1:0]  mag_axis;
        logic signed [ANG_W-1:0] az;
        logic signed [ANG_W-1:0] el;
        t_flags                  flags;
    } t_cdata;

endpackage

/* design/c2s_if.sv */
interface c2s_in_if #(
    parameter int CW = c2s_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

interface c2s_out_if #(
    parameter int CW  = c2s_pkg::COORD_WIDTH_DEF,
    parameter int AFB = c2s_pkg::ANGLE_FRAC_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CW-1:0]           range_out;
    logic [9+AFB-1:0]        azimuth;
    logic signed [8+AFB-1:0] elevation;

    modport source (output valid, output range_out, output azimuth, output elevation,
                    input ready);
    modport sink (input valid, input range_out, input azimuth, input elevation,
                  output ready);
endinterface

/* design/c2s_cordic_cell.sv */
module c2s_cordic_cell #(
    parameter bit PASS_EL = 1'b0,
    parameter int IDX     = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  c2s_pkg::t_cdata i_d,
    output c2s_pkg::t_cdata o_q
);
    import c2s_pkg::*;

    logic signed [DP_W-1:0]  cx;
    logic signed [DP_W-1:0]  cy;
    logic signed [DP_W-1:0]  dx;
    logic signed [DP_W-1:0]  dy;
    logic signed [ANG_W-1:0] base;
    logic signed [ANG_W-1:0] step;
    t_cdata                  n_q;
    t_cdata                  r_q;

    always_comb begin
        n_q  = i_d;
        cx   = i_d.x;
        cy   = i_d.y;
        base = PASS_EL ? i_d.el : i_d.az;
        // first elevation cell loads horizontal magnitude against scaled z
        if (PASS_EL && IDX == 0) begin
            cx   = (i_d.flags.x_zero || i_d.flags.y_zero) ? i_d.mag_axis : i_d.x;
            cy   = i_d.zg;
            base = '0;
        end
        dx   = cy >>> IDX;
        dy   = cx >>> IDX;
        step = ATAN_DEG[IDX];
        if (cy > 0) begin
            n_q.x = cx + dx;
            n_q.y = cy - dy;
            base  = base + step;
        end else begin
            n_q.x = cx - dx;
            n_q.y = cy + dy;
            base  = base - step;
        end
        if (PASS_EL) begin
            n_q.el = base;
        end else begin
            n_q.az = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* design/c2s_sqrt_cell.sv */
module c2s_sqrt_cell #(
    parameter int CW = c2s_pkg::COORD_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*CW-1:0] i_n,
    input  logic [CW+1:0]   i_rem,
    input  logic [CW-1:0]   i_root,
    output logic [2*CW-1:0] o_n,
    output logic [CW+1:0]   o_rem,
    output logic [CW-1:0]   o_root
);
    import c2s_pkg::*;

    logic [CW+3:0]   tmp;
    logic [CW+3:0]   trial;
    logic [CW+1:0]   n_rem;
    logic [CW-1:0]   n_root;
    logic [2*CW-1:0] r_n;
    logic [CW+1:0]   r_rem;
    logic [CW-1:0]   r_root;

    // one root digit per cell, restoring form
    always_comb begin
        tmp   = {i_rem, i_n[2*CW-1 -: 2]};
        trial = {2'b00, i_root, 2'b01};
        if (tmp >= trial) begin
            n_rem  = (CW+2)'(tmp - trial);
            n_root = {i_root[CW-2:0], 1'b1};
        end else begin
            n_rem  = tmp[CW+1:0];
            n_root = {i_root[CW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[2*CW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

/* design/c2s_dly.sv */
module c2s_dly #(
    parameter int W = 1,
    parameter int D = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    import c2s_pkg::*;

    generate
        if (D == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_line [D];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_line[0] <= i_d;
                    for (int k = 1; k < D; k++) begin
                        r_line[k] <= r_line[k-1];
                    end
                end
            end
            assign o_q = r_line[D-1];
        end
    endgenerate

endmodule

/* design/cartesian_to_spherical.sv */
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | coord_x, coord_y, coord_z (signed)
// o_out   | out | valid / ready | range_out, azimuth, elevation (signed)
//
// one item per clock while the output is not stalled; latency is set by the cordic
// cell row (azimuth cells then elevation cells) or the square-root digit row,
// whichever is longer
// synchronous active-low reset clears only the valid bits; input is not ready
// while reset is held
// the whole row advances together; it holds only while the output register
// is full and not taken
module cartesian_to_spherical #(
    parameter int COORD_WIDTH     = c2s_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = c2s_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    c2s_in_if.sink    i_in,
    c2s_out_if.source o_out
);
    import c2s_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int S         = CORDIC_STAGES;
    localparam int G         = GUARD_TOP - CW;     // fraction bits of scaled coords
    localparam int GAIN_SHL  = (G >= 30) ? G - 30 : 0;
    localparam int GAIN_SHR  = (G >= 30) ? 0 : 30 - G;
    localparam logic [DP_W-1:0] GAIN_CORE = (GAIN_Q30 >> GAIN_SHR);
    localparam int LAT       = (CW > 2 * S) ? CW : 2 * S;
    localparam int AZ_W      = 9 + ANGLE_FRAC_BITS;
    localparam int EL_W      = 8 + ANGLE_FRAC_BITS;
    localparam int DROP      = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] HALF       = 32'sd1 <<< (DROP - 1);
    localparam logic signed [ANG_W-1:0] FULL_TURN  = 32'sd360 <<< ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] QUARTER    = 32'sd90 <<< ANGLE_FRAC_BITS;

    // ---------------- flow control ----------------
    logic          en;
    logic          accept;
    logic [LAT+1:0] r_vld;
    logic          r_out_valid;

    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en && i_rst_n;
    assign accept      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT:0], accept};
            r_out_valid <= r_vld[LAT+1];
        end
    end

    // ---------------- stage 1: squares and gain products ----------------
    logic [CW-1:0]          ax;
    logic [CW-1:0]          ay;
    logic [CW-1:0]          az_abs;
    logic [CW:0]            asum;
    logic signed [CW-1:0]   r1_x;
    logic signed [CW-1:0]   r1_y;
    logic signed [CW-1:0]   r1_z;
    logic [2*CW-1:0]        r1_sqx;
    logic [2*CW-1:0]        r1_sqy;
    logic [2*CW-1:0]        r1_sqz;
    logic signed [CW+31:0]  r1_zprod;
    logic [CW+31:0]         r1_aprod;
    logic signed [CW+31:0]  zext;
    logic signed [CW+31:0]  gcore_s;

    // magnitudes; the most negative value maps to its unsigned magnitude
    assign ax     = i_in.coord_x[CW-1] ? CW'(-i_in.coord_x) : i_in.coord_x;
    assign ay     = i_in.coord_y[CW-1] ? CW'(-i_in.coord_y) : i_in.coord_y;
    assign az_abs = i_in.coord_z[CW-1] ? CW'(-i_in.coord_z) : i_in.coord_z;
    assign asum   = {1'b0, ax} + {1'b0, ay};
    assign zext    = (CW+32)'(i_in.coord_z);
    assign gcore_s = (CW+32)'(GAIN_CORE[30:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x     <= i_in.coord_x;
            r1_y     <= i_in.coord_y;
            r1_z     <= i_in.coord_z;
            r1_sqx   <= (2*CW)'(ax) * (2*CW)'(ax);
            r1_sqy   <= (2*CW)'(ay) * (2*CW)'(ay);
            r1_sqz   <= (2*CW)'(az_abs) * (2*CW)'(az_abs);
            r1_zprod <= zext * gcore_s;
            // axis case only: one of |x|, |y| is zero
            r1_aprod <= (CW+32)'(asum) * (CW+32)'(GAIN_CORE[30:0]);
        end
    end

    // ---------------- stage 2: sum and cordic entry ----------------
    logic [2*CW+1:0]         sum_w;
    logic [2*CW-1:0]         r2_sum;
    logic signed [DP_W-1:0]  xs;
    logic signed [DP_W-1:0]  ys;
    t_cdata                  n2_c;
    t_cdata                  r2_c;

    assign sum_w = (2*CW+2)'(r1_sqx) + (2*CW+2)'(r1_sqy) + (2*CW+2)'(r1_sqz);

    always_comb begin
        xs = DP_W'(r1_x) <<< G;
        ys = DP_W'(r1_y) <<< G;
        n2_c.flags.x_zero = (r1_x == '0);
        n2_c.flags.y_zero = (r1_y == '0);
        n2_c.flags.z_zero = (r1_z == '0);
        n2_c.flags.x_neg  = r1_x[CW-1];
        n2_c.flags.y_pos  = !r1_y[CW-1] && (r1_y != '0);
        n2_c.flags.z_pos  = !r1_z[CW-1] && (r1_z != '0);
        // left half plane: rotate by 180 degrees before vectoring
        if (r1_x[CW-1]) begin
            n2_c.x  = -xs;
            n2_c.y  = -ys;
            n2_c.az = DEG_180;
        end else begin
            n2_c.x  = xs;
            n2_c.y  = ys;
            n2_c.az = '0;
        end
        n2_c.el       = '0;
        n2_c.zg       = DP_W'(r1_zprod) <<< GAIN_SHL;
        n2_c.mag_axis = DP_W'(r1_aprod) <<< GAIN_SHL;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sum <= sum_w[2*CW-1:0];
            r2_c   <= n2_c;
        end
    end

    // ---------------- cordic cell row: azimuth then elevation ----------------
    t_cdata c_data [2*S+1];
    t_cdata c_end;

    assign c_data[0] = r2_c;

    generate
        for (genvar k = 0; k < 2 * S; k++) begin : g_cordic
            c2s_cordic_cell #(
                .PASS_EL (k >= S),
                .IDX     (k % S)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (c_data[k]),
                .o_q   (c_data[k+1])
            );
        end
    endgenerate

    c2s_dly #(.W($bits(t_cdata)), .D(LAT - 2 * S)) u_cdly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (c_data[2*S]),
        .o_q   (c_end)
    );

    // ---------------- square-root digit row ----------------
    logic [2*CW-1:0] s_n    [CW+1];
    logic [CW+1:0]   s_rem  [CW+1];
    logic [CW-1:0]   s_root [CW+1];
    logic [CW+1:0]   q_rem;
    logic [CW-1:0]   q_root;

    assign s_n[0]    = r2_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    generate
        for (genvar k = 0; k < CW; k++) begin : g_sqrt
            c2s_sqrt_cell #(.CW(CW)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_n    (s_n[k]),
                .i_rem  (s_rem[k]),
                .i_root (s_root[k]),
                .o_n    (s_n[k+1]),
                .o_rem  (s_rem[k+1]),
                .o_root (s_root[k+1])
            );
        end
    endgenerate

    c2s_dly #(.W(2 * CW + 2), .D(LAT - CW)) u_sdly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({s_rem[CW], s_root[CW]}),
        .o_q   ({q_rem, q_root})
    );

    // ---------------- output stage: rounding and special cases ----------------
    logic signed [ANG_W-1:0] az_full;
    logic [ANG_W-1:0]        az_sum;
    logic [ANG_W-1:0]        azq;
    logic signed [ANG_W-1:0] el_sum;
    logic signed [ANG_W-1:0] elq;
    logic [CW-1:0]           n_range;
    logic [CW-1:0]           r_range;
    logic [AZ_W-1:0]         r_az;
    logic signed [EL_W-1:0]  r_el;

    always_comb begin
        // range: round up when the remainder exceeds the root
        n_range = (q_rem > (CW+2)'(q_root)) ? CW'(q_root + 1'b1) : q_root;

        if (c_end.flags.y_zero) begin
            az_full = c_end.flags.x_neg ? DEG_180 : '0;
        end else if (c_end.flags.x_zero) begin
            az_full = c_end.flags.y_pos ? DEG_90 : DEG_270;
        end else begin
            az_full = c_end.az + ((c_end.az < 0) ? DEG_360 : 32'sd0);
        end
        az_sum = ANG_W'(az_full + HALF);
        azq    = az_sum >> DROP;
        // wrap an azimuth that rounds to a full turn
        if (azq >= ANG_W'(FULL_TURN)) begin
            azq = azq - ANG_W'(FULL_TURN);
        end

        el_sum = c_end.el + HALF;
        if (c_end.flags.z_zero) begin
            elq = '0;
        end else if (c_end.flags.x_zero && c_end.flags.y_zero) begin
            elq = c_end.flags.z_pos ? QUARTER : -QUARTER;
        end else begin
            elq = el_sum >>> DROP;
            if (elq > QUARTER) begin
                elq = QUARTER;
            end else if (elq < -QUARTER) begin
                elq = -QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_range <= n_range;
            r_az    <= azq[AZ_W-1:0];
            r_el    <= elq[EL_W-1:0];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.range_out = r_range;
    assign o_out.azimuth   = r_az;
    assign o_out.elevation = r_el;

endmodule
